// ===== hdl/gc_pkg.sv =====
`default_nettype none

package gc_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int ROW_W            = 64;
  localparam int VIDX_W           = 6;
  localparam int COLOR_W          = 7;

  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic             last_row;
  } in_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]  vertex_index;
    logic [COLOR_W-1:0] vertex_color;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEARCH
  } gc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic search_step;
    logic finish;
  } gc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic color_free;
    logic out_full;
  } gc_sts_t;

endpackage

`default_nettype wire

// ===== hdl/greedy_graph_coloring_core.sv =====
// Flow: after the input transfer the core scans every earlier vertex through the colour
//   memory's single read port (one earlier vertex a cycle), then searches for the first
//   free colour one colour a cycle and loads the result into the output register once it
//   can take it; the next row is taken only once the controller is back in idle.
// Reset (rst_n, synchronous, active low) idles the controller, empties the output register
//   and restarts the vertex count at 0; the colour memory is not cleared.
`default_nettype none

module greedy_graph_coloring_core #(
  parameter int MAX_VERTICES = gc_pkg::MAX_VERTICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // adjacency rows in
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gc_pkg::in_item_t  in_data,
  // colour results out
  output logic                   out_valid,
  input  wire logic              out_stall,
  output gc_pkg::out_item_t      out_data
);

  gc_pkg::gc_cmd_t cmd;
  gc_pkg::gc_sts_t sts;

  // Controller: idle -> scan earlier neighbours -> search first free colour.
  // The row is taken only in idle; a finished result waits in the output
  // register so the next row can be taken while it is pending.
  gc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: colour memory, used-colour set, scan and search counters,
  // vertex counter and the output register.
  gc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // an accepted row always starts a scan, which stalls the input
  a_busy_after_take : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after a transfer");

  // greedy colour never exceeds index + 1 and is never zero
  a_color_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.vertex_color != gc_pkg::COLOR_W'(0)) &&
      (out_data.vertex_color <=
       (gc_pkg::COLOR_W'(out_data.vertex_index) + gc_pkg::COLOR_W'(1))))
    else $error("colour out of range for vertex index");

  // a new result only appears as the controller returns to idle
  a_result_ends_item : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish) |=> (out_valid && !in_stall))
    else $error("result not presented on return to idle");

  // vertex index stays inside the graph size
  a_index_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.vertex_index <= gc_pkg::VIDX_W'(MAX_VERTICES - 1)))
    else $error("vertex index beyond graph size");

endmodule

`default_nettype wire

// ===== hdl/gc_ctrl.sv =====
`default_nettype none

module gc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire gc_pkg::gc_sts_t  sts,
  output gc_pkg::gc_cmd_t       cmd
);

  gc_pkg::gc_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gc_pkg::ST_SCAN;
      end
      gc_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = gc_pkg::ST_SEARCH;
      end
      gc_pkg::ST_SEARCH: begin
        if (sts.color_free && !sts.out_full) state_nxt = gc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      gc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      gc_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      gc_pkg::ST_SEARCH: begin
        cmd.search_step = !sts.color_free;
        cmd.finish      = sts.color_free && !sts.out_full;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gc_datapath.sv =====
`default_nettype none

module gc_datapath #(
  parameter int MAX_VERTICES = gc_pkg::MAX_VERTICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gc_pkg::gc_cmd_t   cmd,
  output gc_pkg::gc_sts_t        sts,
  input  wire gc_pkg::in_item_t  in_data,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output gc_pkg::out_item_t      out_data
);

  localparam int AW = $clog2(MAX_VERTICES);

  logic [MAX_VERTICES-1:0] row_r, row_nxt;
  logic                    last_r, last_nxt;
  logic [AW-1:0]           vcnt_r, vcnt_nxt;
  logic [AW-1:0]           k_r, k_nxt;
  logic [AW-1:0]           c0_r, c0_nxt;     // colour minus one under test
  logic [MAX_VERTICES-1:0] used_r, used_nxt; // bit n: colour n+1 taken
  logic                    hit_r, hit_nxt;
  logic [AW-1:0]           rd_r;
  logic                    out_valid_r, out_valid_nxt;
  gc_pkg::out_item_t       out_r, out_nxt;

  logic [AW-1:0] mem [MAX_VERTICES];

  assign sts.scan_done  = (k_r == vcnt_r);
  assign sts.color_free = !used_r[c0_r];
  assign sts.out_full   = out_valid_r && out_stall;

  always_comb begin
    row_nxt       = row_r;
    last_nxt      = last_r;
    vcnt_nxt      = vcnt_r;
    k_nxt         = k_r;
    c0_nxt        = c0_r;
    used_nxt      = used_r;
    hit_nxt       = 1'b0;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    // mark the colour read for the previous neighbour
    if (hit_r) used_nxt[rd_r] = 1'b1;

    if (cmd.load) begin
      row_nxt  = in_data.row_bits[MAX_VERTICES-1:0];
      last_nxt = in_data.last_row;
      k_nxt    = '0;
      c0_nxt   = '0;
      used_nxt = '0;
    end

    if (cmd.scan_step) begin
      hit_nxt = row_r[k_r] && (k_r != vcnt_r);
      if (k_r != vcnt_r) k_nxt = k_r + AW'(1);
    end

    if (cmd.search_step) c0_nxt = c0_r + AW'(1);

    if (cmd.finish) begin
      out_valid_nxt        = 1'b1;
      out_nxt.vertex_index = gc_pkg::VIDX_W'(vcnt_r);
      out_nxt.vertex_color = gc_pkg::COLOR_W'(c0_r) + gc_pkg::COLOR_W'(1);
      if (last_r || vcnt_r == AW'(MAX_VERTICES - 1)) begin
        vcnt_nxt = '0;
      end else begin
        vcnt_nxt = vcnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) mem[vcnt_r] <= c0_r;
    rd_r <= mem[k_r];
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    last_r <= last_nxt;
    k_r    <= k_nxt;
    c0_r   <= c0_nxt;
    used_r <= used_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vcnt_r      <= vcnt_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
